// File: hw/rtl/rsch_pkg.sv
// Package for the ray-sphere closest-hit block: shared types and constants.
// No dependencies; the front end, queue, back end and top level import it.
package rsch_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

  // Largest reportable distance, unsigned Q15.16.
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  // Multiplier steps of the back end: dot product, L.L, radius^2, tca^2.
  localparam logic [3:0] STEP_LAST = 4'd10;
  // Number of root bits minus one.
  localparam logic [5:0] SQRT_LAST = 6'd51;

  // Word held in the queue between front and back end.
  typedef struct packed {
    logic signed [32:0] l_x;
    logic signed [32:0] l_y;
    logic signed [32:0] l_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [9:0]         sphere_id;
    logic               last_sphere;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_SQRT,
    ST_UPDATE,
    ST_FINISH
  } back_state_e;

endpackage

// File: hw/rtl/rsch_if.sv
// Channel interfaces of the ray-sphere closest-hit block.
// Depends on nothing; used by the top level, the front end and the back end.
interface rsch_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        radius;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [9:0]         sphere_id;
  logic               last_sphere;
  modport source (output valid, dir_x, dir_y, dir_z, center_x, center_y, center_z,
                  radius, red, green, blue, sphere_id, last_sphere, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, center_x, center_y, center_z,
                radius, red, green, blue, sphere_id, last_sphere, output ready);
endinterface

interface rsch_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;
  logic [7:0]  hit_red;
  logic [7:0]  hit_green;
  logic [7:0]  hit_blue;
  logic [9:0]  hit_id;
  modport source (output valid, hit, distance, hit_red, hit_green, hit_blue, hit_id,
                  input ready);
  modport sink (input valid, hit, distance, hit_red, hit_green, hit_blue, hit_id,
                output ready);
endinterface

interface rsch_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rsch_front.sv
// Front end: holds the ray origin and forms L = center - origin per word.
// Depends on rsch_pkg and the channel interfaces.
module rsch_front
  import rsch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rsch_in_if.sink    in_i,
  rsch_cfg_if.sink   cfg_i,
  input  logic       q_full_i,
  output logic       push_o,
  output item_t      item_o
);

  logic signed [31:0] org_x_q, org_y_q, org_z_q;

  // Origin registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ORIGIN_X: org_x_q <= cfg_i.data;
        CFG_ORIGIN_Y: org_y_q <= cfg_i.data;
        CFG_ORIGIN_Z: org_z_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A word is taken whenever the queue has room.
  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  // Offset from origin to center, kept exact in 33 bits.
  always_comb begin
    item_o.l_x         = 33'(in_i.center_x) - 33'(org_x_q);
    item_o.l_y         = 33'(in_i.center_y) - 33'(org_y_q);
    item_o.l_z         = 33'(in_i.center_z) - 33'(org_z_q);
    item_o.dir_x       = in_i.dir_x;
    item_o.dir_y       = in_i.dir_y;
    item_o.dir_z       = in_i.dir_z;
    item_o.radius      = in_i.radius;
    item_o.red         = in_i.red;
    item_o.green       = in_i.green;
    item_o.blue        = in_i.blue;
    item_o.sphere_id   = in_i.sphere_id;
    item_o.last_sphere = in_i.last_sphere;
  end

endmodule

// File: hw/rtl/rsch_queue.sv
// Small queue between front and back end.
// Depends on rsch_pkg for the word type.
module rsch_queue
  import rsch_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  avail_o,
  output item_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/rsch_back.sv
// Back end: one shared multiplier, a bit-serial square root, the nearest-hit
// state and the result register. Depends on rsch_pkg and rsch_res_if.
module rsch_back
  import rsch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  item_t      head_i,
  output logic       pop_o,
  rsch_res_if.source res_o
);

  back_state_e        state_q, state_d;
  logic [3:0]         step_q, step_d;
  logic [5:0]         cnt_q, cnt_d;
  logic signed [67:0] prod_q, prod_d;
  logic signed [67:0] dot_q, dot_d;
  logic [66:0]        ll_q, ll_d;
  logic [103:0]       lim_q, lim_d;
  logic [103:0]       rad_q, rad_d;
  logic [51:0]        root_q, root_d;
  logic [53:0]        rem_q, rem_d;
  logic               best_valid_q, best_valid_d;
  logic [30:0]        best_dist_q, best_dist_d;
  logic [7:0]         best_red_q, best_red_d, best_green_q, best_green_d;
  logic [7:0]         best_blue_q, best_blue_d;
  logic [9:0]         best_id_q, best_id_d;
  logic               out_valid_q, out_valid_d, out_load;
  logic               out_hit_q;
  logic [30:0]        out_dist_q;
  logic [7:0]         out_red_q, out_green_q, out_blue_q;
  logic [9:0]         out_id_q;

  logic signed [33:0] mul_a, mul_b;
  logic [50:0]        tca;
  logic [55:0]        rem_sh, trial;
  logic [52:0]        t_full;
  logic [30:0]        t_sat;

  assign tca = dot_q[66:16];

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (step_q)
      4'd0:    begin mul_a = 34'(head_i.l_x);   mul_b = 34'(head_i.dir_x); end
      4'd1:    begin mul_a = 34'(head_i.l_y);   mul_b = 34'(head_i.dir_y); end
      4'd2:    begin mul_a = 34'(head_i.l_z);   mul_b = 34'(head_i.dir_z); end
      4'd3:    begin mul_a = 34'(head_i.l_x);   mul_b = 34'(head_i.l_x);   end
      4'd4:    begin mul_a = 34'(head_i.l_y);   mul_b = 34'(head_i.l_y);   end
      4'd5:    begin mul_a = 34'(head_i.l_z);   mul_b = 34'(head_i.l_z);   end
      4'd6:    begin mul_a = {3'b0, head_i.radius}; mul_b = {3'b0, head_i.radius}; end
      4'd7:    begin mul_a = {9'b0, tca[50:26]};    mul_b = {9'b0, tca[50:26]};    end
      4'd8:    begin mul_a = {9'b0, tca[50:26]};    mul_b = {8'b0, tca[25:0]};     end
      4'd9:    begin mul_a = {8'b0, tca[25:0]};     mul_b = {8'b0, tca[25:0]};     end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod_d = 68'(mul_a) * 68'(mul_b);
  end

  // Square root step and candidate distance.
  always_comb begin
    rem_sh = {rem_q, rad_q[103:102]};
    trial  = {2'b0, root_q, 2'b01};
    if (root_q > 52'(tca)) begin
      t_full = 53'(tca) + 53'(root_q);
    end else begin
      t_full = 53'(tca) - 53'(root_q);
    end
    t_sat = (t_full > 53'(DIST_MAX)) ? DIST_MAX : t_full[30:0];
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    dot_d        = dot_q;
    ll_d         = ll_q;
    lim_d        = lim_q;
    rad_d        = rad_q;
    root_d       = root_q;
    rem_d        = rem_q;
    best_valid_d = best_valid_q;
    best_dist_d  = best_dist_q;
    best_red_d   = best_red_q;
    best_green_d = best_green_q;
    best_blue_d  = best_blue_q;
    best_id_d    = best_id_q;
    out_load     = 1'b0;
    pop_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          state_d = ST_MUL;
          step_d  = '0;
          dot_d   = '0;
          ll_d    = '0;
          lim_d   = '0;
        end
      end
      ST_MUL: begin
        // Each product is registered and accumulated in the following step.
        unique case (step_q)
          4'd1, 4'd2, 4'd3: dot_d = dot_q + prod_q;
          4'd4, 4'd5, 4'd6: ll_d  = ll_q + prod_q[66:0];
          4'd7:  lim_d = lim_q + {36'b0, prod_q};
          4'd8:  lim_d = lim_q + {prod_q[51:0], 52'b0};
          4'd9:  lim_d = lim_q + {9'b0, prod_q, 27'b0};
          4'd10: lim_d = lim_q + {36'b0, prod_q};
          default: ;
        endcase
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Behind the origin or missed: no candidate.
        if (dot_q[67] || (lim_q < {37'b0, ll_q})) begin
          state_d = ST_FINISH;
        end else begin
          rad_d   = lim_q - {37'b0, ll_q};
          root_d  = '0;
          rem_d   = '0;
          cnt_d   = SQRT_LAST;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // One root bit per cycle.
        if (rem_sh >= trial) begin
          rem_d  = 54'(rem_sh - trial);
          root_d = {root_q[50:0], 1'b1};
        end else begin
          rem_d  = 54'(rem_sh);
          root_d = {root_q[50:0], 1'b0};
        end
        rad_d = {rad_q[101:0], 2'b00};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // Strictly nearer positive hits replace the best.
        if (t_full != '0 && (!best_valid_q || t_sat < best_dist_q)) begin
          best_valid_d = 1'b1;
          best_dist_d  = t_sat;
          best_red_d   = head_i.red;
          best_green_d = head_i.green;
          best_blue_d  = head_i.blue;
          best_id_d    = head_i.sphere_id;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!head_i.last_sphere) begin
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end else if (!out_valid_q || res_o.ready) begin
          out_load     = 1'b1;
          pop_o        = 1'b1;
          best_valid_d = 1'b0;
          best_dist_d  = '0;
          best_red_d   = '0;
          best_green_d = '0;
          best_blue_d  = '0;
          best_id_d    = '0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      best_valid_q <= 1'b0;
      best_dist_q  <= '0;
      best_red_q   <= '0;
      best_green_q <= '0;
      best_blue_q  <= '0;
      best_id_q    <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      best_valid_q <= best_valid_d;
      best_dist_q  <= best_dist_d;
      best_red_q   <= best_red_d;
      best_green_q <= best_green_d;
      best_blue_q  <= best_blue_d;
      best_id_q    <= best_id_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    dot_q  <= dot_d;
    ll_q   <= ll_d;
    lim_q  <= lim_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
    if (out_load) begin
      out_hit_q   <= best_valid_q;
      out_dist_q  <= best_dist_q;
      out_red_q   <= best_red_q;
      out_green_q <= best_green_q;
      out_blue_q  <= best_blue_q;
      out_id_q    <= best_id_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.hit       = out_hit_q;
  assign res_o.distance  = out_dist_q;
  assign res_o.hit_red   = out_red_q;
  assign res_o.hit_green = out_green_q;
  assign res_o.hit_blue  = out_blue_q;
  assign res_o.hit_id    = out_id_q;

endmodule

// File: hw/rtl/ray_sphere_closest_hit.sv
// Top level of the ray-sphere closest-hit block.
// Depends on rsch_pkg, the channel interfaces, rsch_front, rsch_queue, rsch_back.
//
// Usage: write the ray origin (Q16.16) on the configuration channel, then
// stream one sphere word per test on the input channel; the word carries the
// unit direction, center, radius, color and id. The word marked last makes
// one result word on the result channel: hit flag, nearest distance, color
// and id; the nearest-hit state is then cleared for the next ray.
// The back end treats one sphere at a time; a rejected one (behind the
// origin or missed) skips the square root. Its work is set by the single
// shared multiplier (eleven steps) and the square root, which makes one
// of 52 root bits per cycle. The front end takes words into a queue of
// QDepth entries while the back end works, so input latency is hidden up to
// that depth. A result is registered when its last word finishes.
// Reset clears the origin to zero, empties the queue and clears the best hit.
// When the receiver stalls, the result stays in its output register and the
// back end waits only when a second result is ready; the queue keeps
// accepting until full.
module ray_sphere_closest_hit
  import rsch_pkg::*;
#(
  parameter int QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsch_in_if.sink    in_i,
  rsch_cfg_if.sink   cfg_i,
  rsch_res_if.source res_o
);

  logic  q_full, q_avail, push, pop;
  item_t push_item, head_item;

  rsch_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  rsch_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .avail_o (q_avail),
    .head_o  (head_item)
  );

  rsch_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .head_i  (head_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// File: hw/rtl/rsch_checker.sv
// Port-level checks for the ray-sphere closest-hit block, bound to the top.
// Depends on the top level's interface ports only.
module rsch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_hit_i,
  input logic [30:0] res_distance_i,
  input logic [9:0]  res_id_i,
  input logic [7:0]  res_red_i
);

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_distance_i)
      && $stable(res_hit_i) && $stable(res_id_i))
    else $error("result word changed while stalled");

  // A miss reports zero distance, id and red.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_hit_i |-> res_distance_i == '0 && res_id_i == '0
      && res_red_i == '0)
    else $error("miss with nonzero fields");

  // A hit is never at distance zero.
  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_hit_i |-> res_distance_i != '0)
    else $error("hit at zero distance");

endmodule

bind ray_sphere_closest_hit rsch_checker u_rsch_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_hit_i      (res_o.hit),
  .res_distance_i (res_o.distance),
  .res_id_i       (res_o.hit_id),
  .res_red_i      (res_o.hit_red)
);
